// ===== design/lst_pkg.sv =====
// Shared types, constants and letter decoding for the letter set table.
`default_nettype none
package lst_pkg;

    localparam int unsigned LETTERS = 26;
    localparam int unsigned KEY_W   = $clog2(LETTERS);
    localparam int unsigned CNT_W   = $clog2(LETTERS + 1);

    localparam logic [7:0] LOWER_A = 8'd97;
    localparam logic [7:0] LOWER_Z = 8'd122;
    localparam logic [7:0] UPPER_A = 8'd65;
    localparam logic [7:0] UPPER_Z = 8'd90;

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_REMOVE   = 2'd1;
    localparam logic [1:0] OP_CONTAINS = 2'd2;
    localparam logic [1:0] OP_GET      = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] letter;
        logic [4:0] position;
    } t_req;

    typedef struct packed {
        logic       found;
        logic [7:0] member;
        logic [4:0] count;
    } t_res;

    typedef struct packed {
        logic lower;
        logic present;
    } t_slot;

    typedef struct packed {
        logic             en;
        logic             set;
        logic             lower;
        logic [KEY_W-1:0] key;
        logic             inc;
        logic             dec;
    } t_wr;

    typedef struct packed {
        logic             ok;
        logic             lower;
        logic [KEY_W-1:0] key;
    } t_key;

    function automatic t_key letter_key(input logic [7:0] ch);
        t_key k;
        k = '0;
        if (ch >= LOWER_A && ch <= LOWER_Z) begin
            k.ok    = 1'b1;
            k.lower = 1'b1;
            k.key   = KEY_W'(ch - LOWER_A);
        end else if (ch >= UPPER_A && ch <= UPPER_Z) begin
            k.ok  = 1'b1;
            k.key = KEY_W'(ch - UPPER_A);
        end
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== design/lst_store.sv =====
// Slot flags and member count with one read port and one write port.
`default_nettype none
module lst_store (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire lst_pkg::t_wr         i_wr,
    input  wire [lst_pkg::KEY_W-1:0]  i_rd_idx,
    output lst_pkg::t_slot            o_slot,
    output logic [lst_pkg::CNT_W-1:0] o_count
);
    import lst_pkg::*;

    t_slot            r_slots [LETTERS];
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LETTERS; i++) begin
                r_slots[i] <= '0;
            end
            r_count <= '0;
        end else if (i_wr.en) begin
            r_slots[i_wr.key] <= i_wr.set ? t_slot'{lower: i_wr.lower, present: 1'b1} : '0;
            r_count <= CNT_W'(r_count + CNT_W'(i_wr.inc) - CNT_W'(i_wr.dec));
        end
    end

    assign o_slot  = (i_rd_idx < KEY_W'(LETTERS)) ? r_slots[i_rd_idx] : '0;
    assign o_count = r_count;

endmodule
`default_nettype wire

// ===== design/lst_seq.sv =====
// Request sequencer: executes set operations and scans the slots for an indexed read.
`default_nettype none
module lst_seq (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire lst_pkg::t_req        i_req,
    input  wire lst_pkg::t_slot       i_slot,
    input  wire [lst_pkg::CNT_W-1:0]  i_count,
    output logic [lst_pkg::KEY_W-1:0] o_rd_idx,
    output lst_pkg::t_wr              o_wr,
    output logic                      o_done,
    output lst_pkg::t_res             o_res,
    output logic                      o_busy
);
    import lst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state           r_state, n_state;
    t_req             r_req, n_req;
    logic [KEY_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_seen, n_seen;
    t_key             key;

    assign key    = letter_key(r_req.letter);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_idx    = r_idx;
        n_seen   = r_seen;
        o_rd_idx = key.key;
        o_wr     = '0;
        o_done   = 1'b0;
        o_res    = '0;
        o_res.count = i_count;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_req.op)
                    OP_ADD: begin
                        o_done   = 1'b1;
                        o_wr.en  = key.ok;
                        o_wr.set = 1'b1;
                        o_wr.lower = key.lower;
                        o_wr.key = key.key;
                        o_wr.inc = key.ok && !i_slot.present;
                        o_res.count = CNT_W'(i_count + CNT_W'(o_wr.inc));
                        n_state  = S_IDLE;
                    end
                    OP_REMOVE: begin
                        o_done   = 1'b1;
                        o_wr.en  = key.ok && i_slot.present;
                        o_wr.key = key.key;
                        o_wr.dec = o_wr.en && (i_count != '0);
                        o_res.count = CNT_W'(i_count - CNT_W'(o_wr.dec));
                        n_state  = S_IDLE;
                    end
                    OP_CONTAINS: begin
                        o_done      = 1'b1;
                        o_res.found = key.ok && i_slot.present;
                        n_state     = S_IDLE;
                    end
                    default: begin
                        if (CNT_W'(r_req.position) < i_count) begin
                            n_idx   = '0;
                            n_seen  = '0;
                            n_state = S_SCAN;
                        end else begin
                            o_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                o_rd_idx = r_idx;
                n_idx    = KEY_W'(r_idx + 1'b1);
                if (i_slot.present && r_seen == CNT_W'(r_req.position)) begin
                    o_done       = 1'b1;
                    o_res.found  = 1'b1;
                    o_res.member = (i_slot.lower ? LOWER_A : UPPER_A) + 8'(r_idx);
                    n_state      = S_IDLE;
                end else begin
                    if (i_slot.present) begin
                        n_seen = CNT_W'(r_seen + 1'b1);
                    end
                    // Past the last slot without a hit only if the count was inconsistent.
                    if (r_idx == KEY_W'(LETTERS - 1)) begin
                        o_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_idx  <= n_idx;
        r_seen <= n_seen;
    end

`ifndef SYNTHESIS
    a_scan_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < KEY_W'(LETTERS)))
        else $error("scan index ran past the last slot");
    a_scan_is_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_req.op == OP_GET))
        else $error("slot scan running for a request other than get element");
    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after a result");
`endif

endmodule
`default_nettype wire

// ===== design/letter_set_table.sv =====
// Top level of the letter set table: storage, sequencer and result register.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------
//  request  | start, busy         | i_req  (op, letter, position)
//  result   | o_strobe            | o_res  (found, member, count)
//
// Add, remove, contains and a get element that misses finish in the execute
// state; the result strobe is registered from the sequencer's done flag.
// A get element that hits slot k scans slots 0 to k, one slot per cycle,
// through the single slot read port; busy holds off new requests meanwhile.
// Reset is synchronous and empties every slot and clears the count.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module letter_set_table (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire lst_pkg::t_req i_req,
    output logic               o_strobe,
    output lst_pkg::t_res      o_res
);
    import lst_pkg::*;

    t_wr              wr;
    t_slot            slot;
    logic [KEY_W-1:0] rd_idx;
    logic [CNT_W-1:0] count;
    logic             done;
    t_res             res;
    logic             r_strobe;
    t_res             r_res;

    lst_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_rd_idx (rd_idx),
        .o_slot   (slot),
        .o_count  (count)
    );

    lst_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_req),
        .i_slot   (slot),
        .i_count  (count),
        .o_rd_idx (rd_idx),
        .o_wr     (wr),
        .o_done   (done),
        .o_res    (res),
        .o_busy   (busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_res <= res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_res.count <= CNT_W'(LETTERS)))
        else $error("member count above the number of letters");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.found) |-> (o_res.member == 8'd0))
        else $error("member byte set on a result without a hit");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result delivered while a transaction is still running");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_letter_set_table.sv =====
// Self-checking testbench for the letter set table: directed table, full sweep, random traffic.
`timescale 1ns / 100ps
module tb_letter_set_table;
    import lst_pkg::*;

    localparam int DIRECTED_N     = 25;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int QUIET_ITEMS    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    // One row of the directed table; the result is used only when typed is set.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] letter;
        logic [4:0] position;
        logic       typed;
        logic       found;
        logic [7:0] member;
        logic [4:0] count;
    } t_step;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_req  i_req   = '0;
    logic  busy;
    logic  o_strobe;
    t_res  o_res;

    t_slot set_slots [LETTERS];
    logic [CNT_W-1:0] set_count = '0;
    t_res  pending_results [$];
    t_res  oldest;
    t_step directed_steps [DIRECTED_N];
    int    errors = 0;
    int    items_sent = 0;
    int    stalled_cycles = 0;
    logic  quiet = 1'b0;

    letter_set_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Applies one request to the shadow set and returns the result it must produce.
    function automatic t_res letter_set_apply(input t_req r);
        t_res res;
        logic is_lower;
        logic is_upper;
        logic is_letter;
        int   k;
        int   seen;
        res       = '0;
        is_lower  = (r.letter >= LOWER_A) && (r.letter <= LOWER_Z);
        is_upper  = (r.letter >= UPPER_A) && (r.letter <= UPPER_Z);
        is_letter = is_lower || is_upper;
        k         = is_lower ? int'(r.letter - LOWER_A) : int'(r.letter - UPPER_A);
        if (!is_letter) k = 0;
        seen      = 0;
        case (r.op)
            OP_ADD: begin
                if (is_letter) begin
                    if (!set_slots[k].present) set_count = set_count + 1'b1;
                    set_slots[k].present = 1'b1;
                    set_slots[k].lower   = is_lower;
                end
            end
            OP_REMOVE: begin
                if (is_letter && set_slots[k].present) begin
                    set_slots[k] = '0;
                    if (set_count != 0) set_count = set_count - 1'b1;
                end
            end
            OP_CONTAINS: begin
                res.found = is_letter && set_slots[k].present;
            end
            default: begin
                if (r.position < set_count) begin
                    for (int i = 0; i < LETTERS; i++) begin
                        if (set_slots[i].present && !res.found) begin
                            if (seen == r.position) begin
                                res.found  = 1'b1;
                                res.member = (set_slots[i].lower ? LOWER_A : UPPER_A) + 8'(i);
                            end else begin
                                seen++;
                            end
                        end
                    end
                end
            end
        endcase
        res.count = set_count;
        return res;
    endfunction

    // Phase 0 leans toward filling the set, phase 1 toward draining it, phase 2 is even.
    function automatic t_req next_random_request(input int phase);
        t_req r;
        int   roll;
        roll = $urandom_range(0, 99);
        case (phase)
            0:       r.op = (roll < 50) ? OP_ADD : (roll < 60) ? OP_REMOVE :
                            (roll < 80) ? OP_CONTAINS : OP_GET;
            1:       r.op = (roll < 10) ? OP_ADD : (roll < 60) ? OP_REMOVE :
                            (roll < 80) ? OP_CONTAINS : OP_GET;
            default: r.op = (roll < 25) ? OP_ADD : (roll < 50) ? OP_REMOVE :
                            (roll < 75) ? OP_CONTAINS : OP_GET;
        endcase
        if ($urandom_range(0, 99) < 85)
            r.letter = ($urandom_range(0, 1) ? LOWER_A : UPPER_A) + 8'($urandom_range(0, 25));
        else
            r.letter = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 80)
            r.position = 5'($urandom_range(0, set_count));
        else
            r.position = 5'($urandom_range(0, 31));
        return r;
    endfunction

    // Offers one transaction, with an optional idle burst first, and records its result.
    task automatic send_request(input t_req r, input logic typed, input t_res typed_res);
        t_res predicted;
        if (!quiet && ((items_sent / 60) % 4 != 3) && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        predicted = letter_set_apply(r);
        pending_results.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result found=%0d member=%0d count=%0d",
                         $time, o_res.found, o_res.member, o_res.count);
                errors++;
            end else begin
                oldest = pending_results.pop_front();
                if (o_res.found !== oldest.found) begin
                    $display("%0t: found expected %0d actual %0d",
                             $time, oldest.found, o_res.found);
                    errors++;
                end
                if (o_res.member !== oldest.member) begin
                    $display("%0t: member expected %0d actual %0d",
                             $time, oldest.member, o_res.member);
                    errors++;
                end
                if (o_res.count !== oldest.count) begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, oldest.count, o_res.count);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe)
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_req r;
        t_res typed_res;
        for (int i = 0; i < LETTERS; i++) set_slots[i] = '0;
        directed_steps = '{
            '{OP_GET,      8'hAA,  5'd0,  1'b1, 1'b0, 8'd0,   5'd0},
            '{OP_CONTAINS, 8'd65,  5'd0,  1'b1, 1'b0, 8'd0,   5'd0},
            '{OP_REMOVE,   8'd122, 5'd31, 1'b1, 1'b0, 8'd0,   5'd0},
            '{OP_ADD,      8'd65,  5'd0,  1'b1, 1'b0, 8'd0,   5'd1},
            '{OP_ADD,      8'd122, 5'd31, 1'b1, 1'b0, 8'd0,   5'd2},
            '{OP_ADD,      8'd64,  5'd0,  1'b1, 1'b0, 8'd0,   5'd2},
            '{OP_ADD,      8'd91,  5'd0,  1'b1, 1'b0, 8'd0,   5'd2},
            '{OP_ADD,      8'd96,  5'd0,  1'b1, 1'b0, 8'd0,   5'd2},
            '{OP_ADD,      8'd123, 5'd0,  1'b1, 1'b0, 8'd0,   5'd2},
            '{OP_ADD,      8'd0,   5'd0,  1'b1, 1'b0, 8'd0,   5'd2},
            '{OP_ADD,      8'd255, 5'd31, 1'b1, 1'b0, 8'd0,   5'd2},
            '{OP_CONTAINS, 8'd97,  5'd0,  1'b1, 1'b1, 8'd0,   5'd2},
            '{OP_CONTAINS, 8'd90,  5'd31, 1'b1, 1'b1, 8'd0,   5'd2},
            '{OP_CONTAINS, 8'd255, 5'd0,  1'b1, 1'b0, 8'd0,   5'd2},
            '{OP_GET,      8'd0,   5'd0,  1'b1, 1'b1, 8'd65,  5'd2},
            '{OP_GET,      8'd255, 5'd1,  1'b1, 1'b1, 8'd122, 5'd2},
            '{OP_GET,      8'd0,   5'd2,  1'b1, 1'b0, 8'd0,   5'd2},
            '{OP_GET,      8'd0,   5'd31, 1'b1, 1'b0, 8'd0,   5'd2},
            '{OP_ADD,      8'd97,  5'd0,  1'b1, 1'b0, 8'd0,   5'd2},
            '{OP_GET,      8'd0,   5'd0,  1'b1, 1'b1, 8'd97,  5'd2},
            '{OP_REMOVE,   8'd90,  5'd0,  1'b1, 1'b0, 8'd0,   5'd1},
            '{OP_REMOVE,   8'd122, 5'd0,  1'b1, 1'b0, 8'd0,   5'd1},
            '{OP_REMOVE,   8'd91,  5'd0,  1'b1, 1'b0, 8'd0,   5'd1},
            '{OP_ADD,      8'd109, 5'd21, 1'b0, 1'b0, 8'd0,   5'd0},
            '{OP_GET,      8'd77,  5'd1,  1'b0, 1'b0, 8'd0,   5'd0}
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIRECTED_N; n++) begin
            r.op             = directed_steps[n].op;
            r.letter         = directed_steps[n].letter;
            r.position       = directed_steps[n].position;
            typed_res.found  = directed_steps[n].found;
            typed_res.member = directed_steps[n].member;
            typed_res.count  = directed_steps[n].count;
            send_request(r, directed_steps[n].typed, typed_res);
        end

        // Fill every slot in random case, read every position, then empty the set.
        typed_res = '0;
        for (int i = 0; i < LETTERS; i++) begin
            r.op       = OP_ADD;
            r.letter   = ($urandom_range(0, 1) ? LOWER_A : UPPER_A) + 8'(i);
            r.position = 5'($urandom_range(0, 31));
            send_request(r, 1'b0, typed_res);
        end
        for (int p = 0; p < 32; p++) begin
            r.op       = OP_GET;
            r.letter   = 8'($urandom_range(0, 255));
            r.position = 5'(p);
            send_request(r, 1'b0, typed_res);
        end
        for (int i = 0; i < LETTERS; i++) begin
            r.op       = OP_REMOVE;
            r.letter   = ($urandom_range(0, 1) ? LOWER_A : UPPER_A) + 8'(i);
            r.position = 5'($urandom_range(0, 31));
            send_request(r, 1'b0, typed_res);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            r = next_random_request((n / 120) % 3);
            send_request(r, 1'b0, typed_res);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
